[sv/twc_pkg.sv]
package twc_pkg;

    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    localparam int TAB_STEP = 4;

    localparam logic [7:0]  CH_NEWLINE       = 8'h0A;
    localparam logic [7:0]  CH_TAB           = 8'h09;
    localparam logic [7:0]  CH_SPACE         = 8'h20;
    localparam logic [15:0] RESET_CELL       = 16'h0720;
    localparam logic [7:0]  TEXT_COLOR_RESET = 8'h07;

    localparam logic [1:0] KIND_PUT   = 2'd0;
    localparam logic [1:0] KIND_CLEAR = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    typedef enum logic [1:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ,
        ST_FILL
    } state_t;

endpackage

[sv/twc_ram.sv]
module twc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = twc_pkg::ROWS_DEF * twc_pkg::COLUMNS_DEF
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[sv/text_console_writer_core.sv]
// Put character, clear, unused kinds and out-of-range reads show their result in the output
// register in the cycle after the transaction; an in-range read passes the RAM read register first.
// Throughput: one put character per cycle while the output is not stalled; an in-range read
// holds the input in ST_READ; a scroll holds it while the new bottom row is blanked; a clear while all are.
// Scrolling rotates a row offset, so no rows are copied in the cell RAM.
// Reset (aresetn low, synchronous) starts a pass writing 0x0720 to every cell.
module text_console_writer_core #(
    parameter int COLUMNS = twc_pkg::COLUMNS_DEF,
    parameter int ROWS    = twc_pkg::ROWS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_kind,
    input  logic [7:0]  s_char_code,
    input  logic [4:0]  s_read_row,
    input  logic [6:0]  s_read_column,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [4:0]  m_cursor_row,
    output logic [6:0]  m_cursor_column,
    output logic [15:0] m_cell_data,
    output logic        m_scrolled
);

    localparam int CELLS  = ROWS * COLUMNS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int COL_W  = $clog2(COLUMNS);

    twc_pkg::state_t state_reg, state_next;

    logic [ROW_W-1:0]  row_reg, row_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  top_reg, top_next;   // physical row shown as logical row 0
    logic [7:0]        text_color_reg;
    logic [ADDR_W-1:0] sweep_addr_reg, sweep_addr_next;
    logic [ADDR_W-1:0] sweep_last_reg, sweep_last_next;
    logic [15:0]       fill_reg, fill_next;
    logic              m_valid_reg, m_valid_next;
    logic [15:0]       m_cell_data_reg, m_cell_data_next;
    logic              m_scrolled_reg, m_scrolled_next;

    logic              accept;
    logic              ram_wr_en;
    logic [ADDR_W-1:0] ram_wr_addr;
    logic [15:0]       ram_wr_data;
    logic              ram_rd_en;
    logic [ADDR_W-1:0] ram_rd_addr;
    logic [15:0]       ram_rd_data;

    // Cursor address
    logic [ROW_W:0]    cur_phys_sum;
    logic [ROW_W:0]    cur_phys;
    logic [ADDR_W-1:0] cur_addr;
    logic [ADDR_W-1:0] top_base;
    logic [COL_W:0]    col_inc;
    logic [COL_W:0]    col_tab;
    logic [ROW_W:0]    row_inc;

    // Read address
    logic [ROW_W+4:0]  rr_ext;
    logic [COL_W+6:0]  rc_ext;
    logic              rd_in_range;
    logic [ROW_W:0]    rd_phys_sum;
    logic [ROW_W:0]    rd_phys;

    logic [ROW_W+4:0]  row_out_ext;
    logic [COL_W+6:0]  col_out_ext;

    assign accept  = s_valid && s_ready;
    assign s_ready = (state_reg == twc_pkg::ST_IDLE) && (!m_valid_reg || m_ready);

    assign cur_phys_sum = {1'b0, row_reg} + {1'b0, top_reg};
    assign cur_phys = (cur_phys_sum >= (ROW_W+1)'(ROWS)) ?
                      cur_phys_sum - (ROW_W+1)'(ROWS) : cur_phys_sum;
    assign cur_addr = ADDR_W'(cur_phys[ROW_W-1:0]) * ADDR_W'(COLUMNS) + ADDR_W'(col_reg);
    assign top_base = ADDR_W'(top_reg) * ADDR_W'(COLUMNS);

    assign col_inc = {1'b0, col_reg} + (COL_W+1)'(1);
    assign col_tab = ({1'b0, col_reg} + (COL_W+1)'(twc_pkg::TAB_STEP))
                     & ~(COL_W+1)'(twc_pkg::TAB_STEP - 1);
    assign row_inc = {1'b0, row_reg} + (ROW_W+1)'(1);

    assign rr_ext      = (ROW_W+5)'(s_read_row);
    assign rc_ext      = (COL_W+7)'(s_read_column);
    assign rd_in_range = (32'(s_read_row) < ROWS) && (32'(s_read_column) < COLUMNS);
    assign rd_phys_sum = {1'b0, rr_ext[ROW_W-1:0]} + {1'b0, top_reg};
    assign rd_phys = (rd_phys_sum >= (ROW_W+1)'(ROWS)) ?
                     rd_phys_sum - (ROW_W+1)'(ROWS) : rd_phys_sum;
    assign ram_rd_addr = ADDR_W'(rd_phys[ROW_W-1:0]) * ADDR_W'(COLUMNS)
                         + ADDR_W'(rc_ext[COL_W-1:0]);

    always_comb begin
        state_next       = state_reg;
        row_next         = row_reg;
        col_next         = col_reg;
        top_next         = top_reg;
        sweep_addr_next  = sweep_addr_reg;
        sweep_last_next  = sweep_last_reg;
        fill_next        = fill_reg;
        m_valid_next     = m_valid_reg;
        m_cell_data_next = m_cell_data_reg;
        m_scrolled_next  = m_scrolled_reg;
        ram_wr_en        = 1'b0;
        ram_wr_addr      = cur_addr;
        ram_wr_data      = {text_color_reg, s_char_code};
        ram_rd_en        = 1'b0;

        unique case (state_reg)
            twc_pkg::ST_INIT, twc_pkg::ST_FILL: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = sweep_addr_reg;
                ram_wr_data = fill_reg;
                if (m_valid_reg && m_ready) begin
                    m_valid_next = 1'b0;
                end
                if (sweep_addr_reg == sweep_last_reg) begin
                    state_next = twc_pkg::ST_IDLE;
                end else begin
                    sweep_addr_next = sweep_addr_reg + ADDR_W'(1);
                end
            end
            twc_pkg::ST_READ: begin
                // output register is free here: it was free when the read was taken
                m_valid_next     = 1'b1;
                m_cell_data_next = ram_rd_data;
                m_scrolled_next  = 1'b0;
                state_next       = twc_pkg::ST_IDLE;
            end
            twc_pkg::ST_IDLE: begin
                if (m_valid_reg && m_ready) begin
                    m_valid_next = 1'b0;
                end
                if (accept) begin
                    logic to_next_row;
                    to_next_row      = 1'b0;
                    m_valid_next     = 1'b1;
                    m_cell_data_next = '0;
                    m_scrolled_next  = 1'b0;
                    unique case (s_kind)
                        twc_pkg::KIND_PUT: begin
                            if (s_char_code == twc_pkg::CH_NEWLINE) begin
                                to_next_row = 1'b1;
                            end else if (s_char_code == twc_pkg::CH_TAB) begin
                                col_next    = col_tab[COL_W-1:0];
                                to_next_row = (col_tab >= (COL_W+1)'(COLUMNS));
                            end else begin
                                ram_wr_en   = 1'b1;
                                col_next    = col_inc[COL_W-1:0];
                                to_next_row = (col_inc >= (COL_W+1)'(COLUMNS));
                            end
                            if (to_next_row) begin
                                col_next = '0;
                                if (row_inc >= (ROW_W+1)'(ROWS)) begin
                                    // old top row becomes the new bottom row: blank it
                                    row_next        = ROW_W'(ROWS - 1);
                                    top_next        = (top_reg == ROW_W'(ROWS - 1)) ?
                                                      '0 : top_reg + ROW_W'(1);
                                    sweep_addr_next = top_base;
                                    sweep_last_next = top_base + ADDR_W'(COLUMNS - 1);
                                    fill_next       = {text_color_reg, twc_pkg::CH_SPACE};
                                    m_scrolled_next = 1'b1;
                                    state_next      = twc_pkg::ST_FILL;
                                end else begin
                                    row_next = row_inc[ROW_W-1:0];
                                end
                            end
                        end
                        twc_pkg::KIND_CLEAR: begin
                            row_next        = '0;
                            col_next        = '0;
                            top_next        = '0;
                            sweep_addr_next = '0;
                            sweep_last_next = ADDR_W'(CELLS - 1);
                            fill_next       = {text_color_reg, twc_pkg::CH_SPACE};
                            state_next      = twc_pkg::ST_FILL;
                        end
                        twc_pkg::KIND_READ: begin
                            if (rd_in_range) begin
                                ram_rd_en    = 1'b1;
                                m_valid_next = 1'b0;
                                state_next   = twc_pkg::ST_READ;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
                state_next = twc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= twc_pkg::ST_INIT;
            row_reg        <= '0;
            col_reg        <= '0;
            top_reg        <= '0;
            text_color_reg <= twc_pkg::TEXT_COLOR_RESET;
            sweep_addr_reg <= '0;
            sweep_last_reg <= ADDR_W'(CELLS - 1);
            fill_reg       <= twc_pkg::RESET_CELL;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            row_reg        <= row_next;
            col_reg        <= col_next;
            top_reg        <= top_next;
            sweep_addr_reg <= sweep_addr_next;
            sweep_last_reg <= sweep_last_next;
            fill_reg       <= fill_next;
            m_valid_reg    <= m_valid_next;
            if (cfg_wr_en) begin
                text_color_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        m_cell_data_reg <= m_cell_data_next;
        m_scrolled_reg  <= m_scrolled_next;
    end

    twc_ram #(
        .WIDTH (16),
        .DEPTH (CELLS)
    ) u_cell_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Cursor registers already hold the state after the transaction in the output register.
    assign row_out_ext     = (ROW_W+5)'(row_reg);
    assign col_out_ext     = (COL_W+7)'(col_reg);
    assign m_valid         = m_valid_reg;
    assign m_cursor_row    = row_out_ext[4:0];
    assign m_cursor_column = col_out_ext[6:0];
    assign m_cell_data     = m_cell_data_reg;
    assign m_scrolled      = m_scrolled_reg;

endmodule

[sv/twc_checker.sv]
module twc_checker #(
    parameter int COLUMNS = twc_pkg::COLUMNS_DEF,
    parameter int ROWS    = twc_pkg::ROWS_DEF
) (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic [1:0]  s_kind,
    input logic        m_valid,
    input logic        m_ready,
    input logic [4:0]  m_cursor_row,
    input logic [6:0]  m_cursor_column,
    input logic [15:0] m_cell_data,
    input logic        m_scrolled
);

    // reset starts the cell clearing pass, so no transaction is taken right after it
    assert property (@(posedge aclk) !aresetn |=> !s_ready)
        else $error("input ready right after reset");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_cursor_row)
            && $stable(m_cursor_column) && $stable(m_cell_data) && $stable(m_scrolled))
        else $error("stalled result changed");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_scrolled |-> m_cursor_row == 5'(ROWS - 1) && m_cursor_column == 7'd0)
        else $error("scroll left cursor off the bottom row start");

    // a clear always starts the blanking pass
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_kind == twc_pkg::KIND_CLEAR |=> !s_ready)
        else $error("clear did not hold the input");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_cell_data != 16'd0 |-> !m_scrolled)
        else $error("read result marked as scrolled");

endmodule

bind text_console_writer_core twc_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_twc_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .s_kind          (s_kind),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_cursor_row    (m_cursor_row),
    .m_cursor_column (m_cursor_column),
    .m_cell_data     (m_cell_data),
    .m_scrolled      (m_scrolled)
);

[tb/sv/tb_text_console_writer_core.sv]
`timescale 1ns / 1ps

module tb_text_console_writer_core;

    localparam int COLS        = twc_pkg::COLUMNS_DEF;
    localparam int NROWS       = twc_pkg::ROWS_DEF;
    localparam int CELLS       = COLS * NROWS;
    // a scroll or clear may still be blanking cells after its result is out
    localparam int FILL_WAIT   = CELLS + 16;
    localparam int PHASE_ITEMS = 270;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    typedef struct packed {
        logic [4:0]  row;
        logic [6:0]  column;
        logic [15:0] cell_word;
        logic        scrolled;
    } cursor_report_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [7:0]  cfg_wr_data = 8'h00;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_kind = twc_pkg::KIND_PUT;
    logic [7:0]  s_char_code = 8'h00;
    logic [4:0]  s_read_row = 5'd0;
    logic [6:0]  s_read_column = 7'd0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [4:0]  m_cursor_row;
    logic [6:0]  m_cursor_column;
    logic [15:0] m_cell_data;
    logic        m_scrolled;

    // console state as the block should hold it
    logic [15:0] model_screen [CELLS];
    int          model_row;
    int          model_col;
    logic [7:0]  model_color;

    cursor_report_t pending_reports[$];
    int mismatch_count = 0;
    int burst_left = 0;
    int hold_cycles = 0;
    int stall_mode = 0;
    int mode_left = 0;

    text_console_writer_core dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_kind          (s_kind),
        .s_char_code     (s_char_code),
        .s_read_row      (s_read_row),
        .s_read_column   (s_read_column),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_cursor_row    (m_cursor_row),
        .m_cursor_column (m_cursor_column),
        .m_cell_data     (m_cell_data),
        .m_scrolled      (m_scrolled)
    );

    always #4 aclk = ~aclk;

    function automatic logic [15:0] blank_cell();
        return {model_color, twc_pkg::CH_SPACE};
    endfunction

    // column to 0, next row; scroll the screen when stepping off the bottom
    function automatic bit step_row();
        model_col = 0;
        model_row++;
        if (model_row < NROWS)
            return 1'b0;
        for (int i = 0; i < CELLS - COLS; i++)
            model_screen[i] = model_screen[i + COLS];
        for (int i = CELLS - COLS; i < CELLS; i++)
            model_screen[i] = blank_cell();
        model_row = NROWS - 1;
        return 1'b1;
    endfunction

    task automatic console_predict(input logic [1:0] kind, input logic [7:0] ch,
                                   input logic [4:0] rr, input logic [6:0] rc);
        cursor_report_t rep;
        bit             sc;
        sc = 1'b0;
        rep.cell_word = 16'h0000;
        case (kind)
            twc_pkg::KIND_PUT: begin
                if (ch == twc_pkg::CH_NEWLINE) begin
                    sc = step_row();
                end else if (ch == twc_pkg::CH_TAB) begin
                    model_col = (model_col + twc_pkg::TAB_STEP) & ~(twc_pkg::TAB_STEP - 1);
                    if (model_col >= COLS)
                        sc = step_row();
                end else begin
                    model_screen[model_row * COLS + model_col] = {model_color, ch};
                    model_col++;
                    if (model_col >= COLS)
                        sc = step_row();
                end
            end
            twc_pkg::KIND_CLEAR: begin
                for (int i = 0; i < CELLS; i++)
                    model_screen[i] = blank_cell();
                model_row = 0;
                model_col = 0;
            end
            twc_pkg::KIND_READ: begin
                if (rr < NROWS && rc < COLS)
                    rep.cell_word = model_screen[rr * COLS + rc];
            end
            default: ;
        endcase
        rep.row      = model_row[4:0];
        rep.column   = model_col[6:0];
        rep.scrolled = sc;
        pending_reports.push_back(rep);
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatch_count < 40)
            $display("ERROR %0t ns: %s got 0x%0h expected 0x%0h", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic send_item(input logic [1:0] kind, input logic [7:0] ch,
                             input logic [4:0] rr, input logic [6:0] rc);
        int gap;
        s_valid       <= 1'b1;
        s_kind        <= kind;
        s_char_code   <= ch;
        s_read_row    <= rr;
        s_read_column <= rc;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        console_predict(kind, ch, rr, rc);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    task automatic put_char(input logic [7:0] ch);
        send_item(twc_pkg::KIND_PUT, ch, 5'($urandom_range(0, 31)),
                  7'($urandom_range(0, 127)));
    endtask

    task automatic read_cell(input int rr, input int rc);
        send_item(twc_pkg::KIND_READ, 8'($urandom_range(0, 255)), 5'(rr), 7'(rc));
    endtask

    // stop offering, let every result drain and any blanking pass finish
    task automatic settle_idle();
        s_valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge aclk);
        repeat (FILL_WAIT) @(posedge aclk);
    endtask

    task automatic write_color(input logic [7:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        model_color = value;
        cfg_wr_en <= 1'b0;
    endtask

    task automatic test_reset_state();
        read_cell(0, 0);
        read_cell(NROWS - 1, COLS - 1);
        read_cell(NROWS, 0);
        read_cell(0, COLS);
        read_cell(31, 127);
        send_item(KIND_UNUSED, 8'hFF, 5'h1F, 7'h7F);
    endtask

    task automatic test_put_characters();
        settle_idle();
        write_color(8'hFF);
        put_char(8'h00);
        put_char(8'hFF);
        put_char(8'h41);
        put_char(twc_pkg::CH_TAB);
        put_char(8'h42);
        put_char(twc_pkg::CH_NEWLINE);
        read_cell(0, 0);
        read_cell(0, 1);
        read_cell(0, 4);
        send_item(KIND_UNUSED, 8'h00, 5'd0, 7'd0);
    endtask

    task automatic test_line_wrap();
        send_item(twc_pkg::KIND_CLEAR, 8'h00, 5'd0, 7'd0);
        // tabs up to the last tab stop, then characters run off the edge
        while (model_col < COLS - twc_pkg::TAB_STEP)
            put_char(twc_pkg::CH_TAB);
        repeat (twc_pkg::TAB_STEP) put_char(8'h5A);
        read_cell(0, COLS - 1);
        // a tab from the last stop wraps on its own
        while (model_col < COLS - twc_pkg::TAB_STEP)
            put_char(twc_pkg::CH_TAB);
        put_char(twc_pkg::CH_TAB);
    endtask

    task automatic test_scroll();
        settle_idle();
        write_color(8'h00);
        while (model_row < NROWS - 1)
            put_char(twc_pkg::CH_NEWLINE);
        put_char(8'h51);
        put_char(twc_pkg::CH_NEWLINE);
        read_cell(NROWS - 2, 0);
        read_cell(NROWS - 1, 0);
        // scroll caused by a character at the right edge, then by a tab
        while (model_col < COLS - twc_pkg::TAB_STEP)
            put_char(twc_pkg::CH_TAB);
        repeat (twc_pkg::TAB_STEP) put_char(8'h7E);
        while (model_col < COLS - twc_pkg::TAB_STEP)
            put_char(twc_pkg::CH_TAB);
        put_char(twc_pkg::CH_TAB);
        read_cell(NROWS - 3, COLS - 1);
    endtask

    task automatic test_clear();
        put_char(8'h2A);
        send_item(twc_pkg::KIND_CLEAR, 8'hFF, 5'h1F, 7'h7F);
        read_cell(0, 0);
        read_cell(NROWS - 1, COLS - 1);
    endtask

    task automatic test_backpressure();
        hold_cycles = 400;
        repeat (60) put_char(8'($urandom_range(32, 126)));
        settle_idle();
    endtask

    task automatic send_random_item();
        int pick;
        int sub;
        logic [7:0] ch;
        pick = $urandom_range(0, 999);
        sub  = $urandom_range(0, 9);
        if (pick < 4) begin
            send_item(twc_pkg::KIND_CLEAR, 8'($urandom), 5'($urandom), 7'($urandom));
        end else if (pick < 30) begin
            send_item(KIND_UNUSED, 8'($urandom), 5'($urandom), 7'($urandom));
        end else if (pick < 230) begin
            if (sub < 2)
                read_cell($urandom_range(0, 31), $urandom_range(0, 127));
            else if (sub < 6)
                read_cell(model_row, $urandom_range(0, COLS - 1));
            else
                read_cell($urandom_range(0, NROWS - 1), $urandom_range(0, COLS - 1));
        end else begin
            if (sub == 0)
                ch = twc_pkg::CH_NEWLINE;
            else if (sub == 1 && $urandom_range(0, 1) == 0)
                ch = twc_pkg::CH_TAB;
            else
                ch = 8'($urandom_range(0, 255));
            put_char(ch);
        end
    endtask

    task automatic test_random_text();
        logic [7:0] colors [6];
        colors = '{8'h00, 8'hFF, 8'($urandom), 8'h1E, 8'($urandom),
                   twc_pkg::TEXT_COLOR_RESET};
        for (int p = 0; p < 6; p++) begin
            settle_idle();
            write_color(colors[p]);
            repeat (PHASE_ITEMS) send_random_item();
        end
    endtask

    // receiver: changes stall pattern every so often, honors long hold requests
    always @(posedge aclk) begin
        if (hold_cycles > 0) begin
            hold_cycles--;
            m_ready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(20, 200);
            end else begin
                mode_left--;
            end
            case (stall_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= ($urandom_range(0, 1) == 1);
                2: m_ready <= ($urandom_range(0, 7) != 0);
                default: m_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge aclk) begin : check_results
        cursor_report_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_reports.size() == 0) begin
                report_mismatch("unexpected transaction, cursor row", m_cursor_row, 0);
            end else begin
                want = pending_reports.pop_front();
                if (m_cursor_row !== want.row)
                    report_mismatch("cursor_row", m_cursor_row, want.row);
                if (m_cursor_column !== want.column)
                    report_mismatch("cursor_column", m_cursor_column, want.column);
                if (m_cell_data !== want.cell_word)
                    report_mismatch("cell_data", m_cell_data, want.cell_word);
                if (m_scrolled !== want.scrolled)
                    report_mismatch("scrolled", m_scrolled, want.scrolled);
            end
        end
    end

    initial begin
        for (int i = 0; i < CELLS; i++)
            model_screen[i] = twc_pkg::RESET_CELL;
        model_row   = 0;
        model_col   = 0;
        model_color = twc_pkg::TEXT_COLOR_RESET;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        test_reset_state();
        test_put_characters();
        test_line_wrap();
        test_scroll();
        test_clear();
        test_backpressure();
        test_random_text();

        s_valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0 && pending_reports.size() == 0)
            $display("PASS text_console_writer_core");
        else
            $display("FAIL text_console_writer_core");
        $finish;
    end

    initial begin
        #8_000_000;
        $display("FAIL text_console_writer_core");
        $finish;
    end

endmodule
